// ===== rtl/core/uniform_interval_exceed_probability_top_macros.svh =====
`ifndef UNIFORM_INTERVAL_EXCEED_PROBABILITY_TOP_MACROS_SVH
`define UNIFORM_INTERVAL_EXCEED_PROBABILITY_TOP_MACROS_SVH

// same-cycle implication
`define UIEP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uiep assertion failed");

// next-cycle implication
`define UIEP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uiep assertion failed");

`endif

// ===== rtl/core/uiep_pkg.sv =====
package uiep_pkg;

    localparam int CW = 16;
    localparam int FB = 16;
    localparam int OW = CW + 2;
    localparam int PW = 2 * OW;
    localparam int QW = FB + 1;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic [CW:0]          diff_t;
    typedef logic [OW-1:0]        opnd_t;
    typedef logic [PW-1:0]        prod_t;
    typedef logic [QW-1:0]        quot_t;

    localparam quot_t ONE  = {1'b1, {FB{1'b0}}};
    localparam quot_t ZERO = '0;

    typedef struct packed {
        prod_t n;
        prod_t d;
        logic  fixed;
        quot_t fval;
        logic  comp;
    } job_t;

    typedef struct packed {
        logic busy;
    } back_status_t;

    function automatic diff_t cdiff(coord_t p, coord_t q);
        return {p[CW-1], p} - {q[CW-1], q};
    endfunction

    function automatic opnd_t ext(diff_t x);
        return {1'b0, x};
    endfunction

endpackage

// ===== rtl/core/uniform_interval_exceed_probability_top.sv =====
// Gives P(a >= b) for a drawn uniformly from [a_low,a_high] and b from [b_low,b_high],
// as Q1.16 rounded down (65536 = 1.0). One request per cycle is taken while nothing
// stalls; a request passes four front stages (order, swap, classify, multiply), the
// two-entry queue, sixteen plus one stages of a restoring divider, and the output
// register. A reversed interval is read with its ends exchanged.
module uniform_interval_exceed_probability_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  uiep_pkg::coord_t  a_low,
    input  uiep_pkg::coord_t  a_high,
    input  uiep_pkg::coord_t  b_low,
    input  uiep_pkg::coord_t  b_high,
    output logic              res_valid,
    input  logic              res_stall,
    output uiep_pkg::quot_t   probability
);
    import uiep_pkg::*;

    `include "uniform_interval_exceed_probability_top_macros.svh"

    logic         fj_valid, fj_stall, bj_valid, bj_stall;
    job_t         fj, bj;
    back_status_t bstat;

    uiep_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .a_low     (a_low),
        .a_high    (a_high),
        .b_low     (b_low),
        .b_high    (b_high),
        .job_valid (fj_valid),
        .job_stall (fj_stall),
        .job       (fj)
    );

    uiep_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fj_valid),
        .push_stall (fj_stall),
        .push_job   (fj),
        .pop_valid  (bj_valid),
        .pop_stall  (bj_stall),
        .pop_job    (bj)
    );

    uiep_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (bj_valid),
        .job_stall   (bj_stall),
        .job         (bj),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .probability (probability),
        .status      (bstat)
    );

    `UIEP_ASSERT_NOW(a_prob_range, res_valid, probability <= ONE)
    `UIEP_ASSERT_NEXT(a_drain, !bstat.busy && res_valid && !res_stall, !res_valid)
    `UIEP_ASSERT_NOW(a_job_in_range, fj_valid && !fj.fixed, fj.n <= fj.d && fj.d != '0)

endmodule

// ===== rtl/core/uiep_front.sv =====
module uiep_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  uiep_pkg::coord_t  a_low,
    input  uiep_pkg::coord_t  a_high,
    input  uiep_pkg::coord_t  b_low,
    input  uiep_pkg::coord_t  b_high,
    output logic              job_valid,
    input  logic              job_stall,
    output uiep_pkg::job_t    job
);
    import uiep_pkg::*;

    logic [3:0] v_reg;
    logic       en;

    coord_t al_reg, ah_reg, bl_reg, bh_reg;
    coord_t x0_reg, x1_reg, y0_reg, y1_reg;
    logic   px_reg, py_reg, sw_reg;
    opnd_t  ma_reg, mb_reg, da_reg, db_reg;
    logic   fixed_reg, comp_reg;
    quot_t  fval_reg;
    job_t   job_reg;

    diff_t  w, v;
    logic   px, py, sw;
    opnd_t  ma_next, mb_next, da_next, db_next;
    logic   fixed_next, comp_next;
    quot_t  fval_next;

    assign en        = !v_reg[3] || !job_stall;
    assign req_stall = !en;
    assign job_valid = v_reg[3];
    assign job       = job_reg;

    assign w  = cdiff(ah_reg, al_reg);
    assign v  = cdiff(bh_reg, bl_reg);
    assign px = (w == '0);
    assign py = (v == '0);
    assign sw = !px && !py && (v > w);

    always_comb
    begin
        ma_next    = '0;
        mb_next    = '0;
        da_next    = opnd_t'(1);
        db_next    = opnd_t'(1);
        fixed_next = 1'b0;
        comp_next  = 1'b0;
        fval_next  = ZERO;
        if (px_reg && py_reg)
        begin
            fixed_next = 1'b1;
            fval_next  = (x0_reg >= y0_reg) ? ONE : ZERO;
        end
        else if (px_reg)
        begin
            if (x0_reg <= y0_reg)
            begin
                fixed_next = 1'b1;
            end
            else if (x0_reg <= y1_reg)
            begin
                ma_next = ext(cdiff(x0_reg, y0_reg));
                mb_next = opnd_t'(1);
                da_next = ext(cdiff(y1_reg, y0_reg));
            end
            else
            begin
                fixed_next = 1'b1;
                fval_next  = ONE;
            end
        end
        else if (py_reg)
        begin
            if (x1_reg <= y0_reg)
            begin
                fixed_next = 1'b1;
            end
            else if (x0_reg <= y0_reg)
            begin
                ma_next = ext(cdiff(x1_reg, y0_reg));
                mb_next = opnd_t'(1);
                da_next = ext(cdiff(x1_reg, x0_reg));
            end
            else
            begin
                fixed_next = 1'b1;
                fval_next  = ONE;
            end
        end
        else
        begin
            if (x1_reg <= y0_reg)
            begin
                fixed_next = 1'b1;
                fval_next  = sw_reg ? ONE : ZERO;
            end
            else if (x1_reg <= y1_reg)
            begin
                ma_next   = ext(cdiff(x1_reg, y0_reg));
                mb_next   = ma_next;
                da_next   = {cdiff(y1_reg, y0_reg), 1'b0};
                db_next   = ext(cdiff(x1_reg, x0_reg));
                comp_next = sw_reg;
            end
            else if (x0_reg <= y0_reg)
            begin
                ma_next   = ext(cdiff(x1_reg, y0_reg)) + ext(cdiff(x1_reg, y1_reg));
                mb_next   = opnd_t'(1);
                da_next   = {cdiff(x1_reg, x0_reg), 1'b0};
                comp_next = sw_reg;
            end
            else if (x0_reg <= y1_reg)
            begin
                ma_next   = ext(cdiff(y1_reg, x0_reg));
                mb_next   = ma_next;
                da_next   = {cdiff(y1_reg, y0_reg), 1'b0};
                db_next   = ext(cdiff(x1_reg, x0_reg));
                comp_next = !sw_reg;
            end
            else
            begin
                fixed_next = 1'b1;
                fval_next  = sw_reg ? ZERO : ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], req_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // order the ends of each interval
            al_reg <= (a_low > a_high) ? a_high : a_low;
            ah_reg <= (a_low > a_high) ? a_low  : a_high;
            bl_reg <= (b_low > b_high) ? b_high : b_low;
            bh_reg <= (b_low > b_high) ? b_low  : b_high;
            // wider interval goes first
            x0_reg <= sw ? bl_reg : al_reg;
            x1_reg <= sw ? bh_reg : ah_reg;
            y0_reg <= sw ? al_reg : bl_reg;
            y1_reg <= sw ? ah_reg : bh_reg;
            px_reg <= px;
            py_reg <= py;
            sw_reg <= sw;
            ma_reg    <= ma_next;
            mb_reg    <= mb_next;
            da_reg    <= da_next;
            db_reg    <= db_next;
            fixed_reg <= fixed_next;
            comp_reg  <= comp_next;
            fval_reg  <= fval_next;
            job_reg.n     <= ma_reg * mb_reg;
            job_reg.d     <= da_reg * db_reg;
            job_reg.fixed <= fixed_reg;
            job_reg.fval  <= fval_reg;
            job_reg.comp  <= comp_reg;
        end
    end

endmodule

// ===== rtl/core/uiep_fifo.sv =====
module uiep_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_stall,
    input  uiep_pkg::job_t  push_job,
    output logic            pop_valid,
    input  logic            pop_stall,
    output uiep_pkg::job_t  pop_job
);
    import uiep_pkg::*;

    job_t       mem [0:1];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign push_stall = (cnt_reg == 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_job    = mem[rp_reg];
    assign push       = push_valid && !push_stall;
    assign pop        = pop_valid && !pop_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/core/uiep_back.sv =====
module uiep_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    job_valid,
    output logic                    job_stall,
    input  uiep_pkg::job_t          job,
    output logic                    res_valid,
    input  logic                    res_stall,
    output uiep_pkg::quot_t         probability,
    output uiep_pkg::back_status_t  status
);
    import uiep_pkg::*;

    logic [FB:0] bv_reg;
    logic        ov_reg;
    logic        en;
    prod_t       r_reg   [0:FB];
    quot_t       q_reg   [0:FB];
    prod_t       d_reg   [0:FB];
    logic        fx_reg  [0:FB];
    logic        cp_reg  [0:FB];
    quot_t       fv_reg  [0:FB];
    quot_t       prob_reg;
    logic [PW:0] t       [1:FB];
    logic        ge      [1:FB];
    logic        ge0;
    quot_t       prob_next;

    assign en          = !ov_reg || !res_stall;
    assign job_stall   = !en;
    assign res_valid   = ov_reg;
    assign probability = prob_reg;
    assign status.busy = |bv_reg;
    assign ge0         = (job.n >= job.d);

    always_comb
    begin
        for (int k = 1; k <= FB; k++)
        begin
            t[k]  = {r_reg[k-1], 1'b0};
            ge[k] = (t[k] >= {1'b0, d_reg[k-1]});
        end
    end

    always_comb
    begin
        if (fx_reg[FB])
        begin
            prob_next = fv_reg[FB];
        end
        else if (cp_reg[FB])
        begin
            prob_next = ONE - q_reg[FB] - quot_t'(r_reg[FB] != '0);
        end
        else
        begin
            prob_next = q_reg[FB];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg <= '0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            bv_reg <= {bv_reg[FB-1:0], job_valid};
            ov_reg <= bv_reg[FB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]  <= ge0 ? job.n - job.d : job.n;
            q_reg[0]  <= quot_t'(ge0);
            d_reg[0]  <= job.d;
            fx_reg[0] <= job.fixed;
            cp_reg[0] <= job.comp;
            fv_reg[0] <= job.fval;
            for (int k = 1; k <= FB; k++)
            begin
                r_reg[k]  <= ge[k] ? PW'(t[k] - {1'b0, d_reg[k-1]}) : PW'(t[k]);
                q_reg[k]  <= {q_reg[k-1][QW-2:0], ge[k]};
                d_reg[k]  <= d_reg[k-1];
                fx_reg[k] <= fx_reg[k-1];
                cp_reg[k] <= cp_reg[k-1];
                fv_reg[k] <= fv_reg[k-1];
            end
            prob_reg <= prob_next;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    import uiep_pkg::*;

    localparam int LATENCY = 22;
    localparam int N_RANDOM = 1930;
    localparam longint CYCLE_LIMIT = 400000;

    class prob_scoreboard;
        logic [16:0] pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        static function logic [16:0] ratio(longint unsigned num, longint unsigned den,
                                           int nbits, output bit inexact);
            longint unsigned q;
            longint unsigned r;
            q = 0;
            r = num;
            inexact = 0;
            if (den == 0)
                return 0;
            if (r > den)
                r = den;
            if (r >= den)
            begin
                q = 1;
                r -= den;
            end
            for (int i = 0; i < nbits; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= den)
                begin
                    r -= den;
                    q |= 1;
                end
            end
            inexact = (r != 0);
            return q[16:0];
        endfunction

        static function logic [16:0] exceed(longint x0, longint x1, longint y0, longint y1);
            longint t;
            bit inexact;
            bit comp;
            bit swapped;
            longint unsigned q;
            longint unsigned w;
            longint unsigned v;
            longint unsigned d;
            inexact = 0;
            comp = 0;
            swapped = 0;
            if (x0 > x1)
            begin
                t = x0; x0 = x1; x1 = t;
            end
            if (y0 > y1)
            begin
                t = y0; y0 = y1; y1 = t;
            end
            if (x0 == x1 && y0 == y1)
                return (x0 >= y0) ? ONE : ZERO;
            if (x0 == x1)
            begin
                if (x0 <= y0)
                    return ZERO;
                if (x0 <= y1)
                    return ratio(x0 - y0, y1 - y0, FB, inexact);
                return ONE;
            end
            if (y0 == y1)
            begin
                if (x1 <= y0)
                    return ZERO;
                if (x0 <= y0)
                    return ratio(x1 - y0, x1 - x0, FB, inexact);
                return ONE;
            end
            if (y1 - y0 > x1 - x0)
            begin
                t = x0; x0 = y0; y0 = t;
                t = x1; x1 = y1; y1 = t;
                swapped = 1;
            end
            w = x1 - x0;
            v = y1 - y0;
            if (x1 <= y0)
                q = 0;
            else if (x1 <= y1)
            begin
                d = x1 - y0;
                q = ratio(d * d, v * w, FB - 1, inexact);
            end
            else if (x0 <= y0)
                q = ratio((x1 - y0) + (x1 - y1), 2 * w, FB, inexact);
            else if (x0 <= y1)
            begin
                d = y1 - x0;
                q = ratio(d * d, v * w, FB - 1, inexact);
                comp = 1;
            end
            else
                q = ONE;
            if (comp != swapped)
                q = ONE - q - (inexact ? 1 : 0);
            return q[16:0];
        endfunction

        function void note_request(coord_t al, coord_t ah, coord_t bl, coord_t bh);
            pending.push_back(exceed(al, ah, bl, bh));
        endfunction

        function void check_result(logic [16:0] got);
            logic [16:0] exp_p;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected probability %0d", $time, got);
                errors++;
                return;
            end
            exp_p = pending.pop_front();
            if (got !== exp_p)
            begin
                $display("%0t: probability expected %0d actual %0d", $time, exp_p, got);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    coord_t a_low;
    coord_t a_high;
    coord_t b_low;
    coord_t b_high;
    logic res_valid;
    logic res_stall;
    quot_t probability;

    prob_scoreboard sb;
    longint cycles;
    bit driving_done;
    bit hold_off;
    bit hold_done;

    uniform_interval_exceed_probability_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .a_low(a_low), .a_high(a_high), .b_low(b_low), .b_high(b_high),
        .res_valid(res_valid), .res_stall(res_stall),
        .probability(probability)
    );

    initial clk = 0;
    always #1 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return coord_t'($urandom_range(0, 40)) - 16'sd20;
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic send_request(coord_t al, coord_t ah, coord_t bl, coord_t bh);
        a_low <= al;
        a_high <= ah;
        b_low <= bl;
        b_high <= bh;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(al, ah, bl, bh);
    endtask

    task automatic send_idle(int n);
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_random();
        coord_t al;
        coord_t ah;
        coord_t bl;
        coord_t bh;
        coord_t c;
        int kind;
        al = rand_coord();
        ah = rand_coord();
        bl = rand_coord();
        bh = rand_coord();
        kind = $urandom_range(0, 9);
        c = coord_t'($urandom_range(0, 200)) - 16'sd100;
        if (kind < 3)
        begin
            al = c + coord_t'($urandom_range(0, 30)) - 16'sd15;
            ah = al + coord_t'($urandom_range(0, 40));
            bl = c + coord_t'($urandom_range(0, 30)) - 16'sd15;
            bh = bl + coord_t'($urandom_range(0, 40));
        end
        else if (kind == 3)
            ah = al;
        else if (kind == 4)
            bh = bl;
        else if (kind < 9)
        begin
            if (al > ah)
            begin
                c = al; al = ah; ah = c;
            end
            if (bl > bh)
            begin
                c = bl; bl = bh; bh = c;
            end
        end
        send_request(al, ah, bl, bh);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        a_low = '0;
        a_high = '0;
        b_low = '0;
        b_high = '0;
        driving_done = 0;
        hold_off = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_request(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_request(16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0000);
        send_request(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_request(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
        send_request(16'sd5, 16'sd5, 16'sd5, 16'sd5);
        send_request(16'sd0, 16'sd0, 16'sd0, 16'sd10);
        send_request(16'sd3, 16'sd3, 16'sd0, 16'sd10);
        send_request(16'sd11, 16'sd11, 16'sd0, 16'sd10);
        send_request(16'sd0, 16'sd10, 16'sd10, 16'sd10);
        send_request(16'sd0, 16'sd10, 16'sd4, 16'sd4);
        send_request(16'sd0, 16'sd10, -16'sd1, -16'sd1);
        send_request(16'sd0, 16'sd10, 16'sd20, 16'sd30);
        send_request(16'sd20, 16'sd30, 16'sd0, 16'sd10);
        send_request(16'sd0, 16'sd10, 16'sd5, 16'sd15);
        send_request(16'sd0, 16'sd20, 16'sd5, 16'sd10);
        send_request(16'sd5, 16'sd15, 16'sd0, 16'sd10);
        send_request(16'sd5, 16'sd10, 16'sd0, 16'sd20);
        send_request(16'sd0, 16'sd3, 16'sd1, 16'sd4);
        send_request(16'sd0, 16'sd7, 16'sd0, 16'sd7);
        send_request(16'sh8000, 16'sh7fff, 16'sh7ffe, 16'sh7fff);
        send_request(16'sh8000, 16'sh8001, 16'sh8000, 16'sh7fff);
        send_request(16'sd10, 16'sd0, 16'sd12, 16'sd2);
        send_request(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555);
        hold_off = 1;
        for (int i = 0; i < 60; i++)
            send_random();
        hold_off = 0;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if ((i / 200) % 3 == 1)
                send_random();
            else
            begin
                send_idle(gap_len());
                send_random();
            end
        end
        req_valid <= 1'b0;
        driving_done = 1;
    end

    initial
    begin
        res_stall = 1'b1;
        hold_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off && !hold_done)
            begin
                // one long hold-off so the pipeline and queue fill up
                res_stall <= 1'b1;
                repeat (150) @(posedge clk);
                hold_done = 1;
            end
            if (($time / 400) % 3 == 2)
                res_stall <= 1'b0;
            else
                res_stall <= (gap_len() != 0);
        end
    end

    always @(posedge clk)
        if (rst_n && res_valid && !res_stall)
            sb.check_result(probability);

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        wait (driving_done);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/uiep_pkg.sv
rtl/core/uiep_front.sv
rtl/core/uiep_fifo.sv
rtl/core/uiep_back.sv
rtl/core/uniform_interval_exceed_probability_top.sv
dv/tb_top.sv
